FILE: hw/rtl/nnp_pkg.sv
// ----------------------------------------------------------------------------
// nnp_pkg
// Shared constants for the 10:10:10 unit-normal packer.
// ----------------------------------------------------------------------------
package nnp_pkg;

  localparam int unsigned FIELD_BITS = 10;  // width of one packed component
  localparam int unsigned UNIT_BITS  = 9;   // magnitude bits of one component
  localparam int unsigned WORD_BITS  = 30;  // three packed components
  localparam int unsigned TDATA_OUT  = 32;  // packed word filled to bytes

  // 511^2 = 2^18 - 2^10 + 1, applied as shifts and adds
  localparam int unsigned SCALE_SQ_HI  = 18;
  localparam int unsigned SCALE_SQ_MID = 10;

endpackage

FILE: hw/rtl/nnp_bit_step.sv
// ----------------------------------------------------------------------------
// nnp_bit_step
// One restoring square-root-quotient step for all three lanes, registered.
// ----------------------------------------------------------------------------
module nnp_bit_step #(
  parameter int unsigned SW  = 34,
  parameter int unsigned PW  = 54,
  parameter int unsigned BIT = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SW-1:0]                        in_sum,
  input  logic [2:0][PW-1:0]                   in_target,
  input  logic [2:0][PW-1:0]                   in_qsq,
  input  logic [2:0][PW-1:0]                   in_qs,
  input  logic [2:0][nnp_pkg::UNIT_BITS-1:0]   in_q,
  input  logic [2:0]                           in_neg,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [SW-1:0]                        out_sum,
  output logic [2:0][PW-1:0]                   out_target,
  output logic [2:0][PW-1:0]                   out_qsq,
  output logic [2:0][PW-1:0]                   out_qs,
  output logic [2:0][nnp_pkg::UNIT_BITS-1:0]   out_q,
  output logic [2:0]                           out_neg
);

  logic [PW-1:0] sum_ext;
  logic [2:0][PW-1:0] cand;
  logic [2:0] take;

  assign in_ready = !out_valid || out_ready;
  assign sum_ext  = PW'(in_sum);

  // (q + 2^b)^2 S = q^2 S + 2^(b+1) q S + 2^(2b) S
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = in_qsq[i] + (in_qs[i] << (BIT + 1)) + (sum_ext << (2 * BIT));
      take[i] = (cand[i] <= in_target[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_sum    <= in_sum;
      out_target <= in_target;
      out_neg    <= in_neg;
      for (int i = 0; i < 3; i++) begin
        if (take[i]) begin
          out_qsq[i] <= cand[i];
          out_qs[i]  <= in_qs[i] + (sum_ext << BIT);
          out_q[i]   <= in_q[i] | nnp_pkg::UNIT_BITS'(1 << BIT);
        end else begin
          out_qsq[i] <= in_qsq[i];
          out_qs[i]  <= in_qs[i];
          out_q[i]   <= in_q[i];
        end
      end
    end
  end

endmodule

FILE: hw/rtl/normal_normalize_pack_10_10_10.sv
// ----------------------------------------------------------------------------
// normal_normalize_pack_10_10_10
// Normalizes a signed 3-vector and packs it as 10:10:10 two's complement.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one vector per item: comp_x, comp_y, comp_z packed in tdata.
//   m_* returns one item per vector: packed_word in tdata (x bits 0-9,
//   y 10-19, z 20-29, top bits zero) and the zero_vector flag in tuser.
//   Each component is floor(511*|c|/sqrt(x^2+y^2+z^2)) with the sign of c,
//   computed exactly in integer arithmetic.
// Pipeline: 13 register stages: magnitude, squares, sum and target, nine
//   quotient bit steps (one bit per stage, shift-add update of q^2*S, no
//   multiplier in the loop), output register.
// Throughput: one item per cycle while the output is not blocked; every stage has its own valid bit.
// Stall: each stage holds when the stage after it is full and blocked;
//   bubbles close up, so the input keeps taking items until the pipe fills.
// Reset: clears every valid bit; the pipe is empty and s_tready is high.
// A zero vector gives packed_word zero and zero_vector high.
// ----------------------------------------------------------------------------
module normal_normalize_pack_10_10_10 #(
  parameter int unsigned COMPONENT_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // comp_x, comp_y, comp_z from the lowest bit, zero filled to bytes
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // packed_word, zero filled to bytes
  output logic [nnp_pkg::TDATA_OUT-1:0]         m_tdata,
  // zero_vector
  output logic                                  m_tuser
);

  localparam int unsigned CB    = COMPONENT_BITS;
  localparam int unsigned SQW   = 2 * CB;
  localparam int unsigned SW    = 2 * CB + 2;
  localparam int unsigned PW    = 2 * CB + 22;
  localparam int unsigned NSTEP = nnp_pkg::UNIT_BITS;
  localparam int unsigned UB    = nnp_pkg::UNIT_BITS;
  localparam int unsigned FB    = nnp_pkg::FIELD_BITS;

  // Stage 0: magnitudes and signs
  logic               v0, r0;
  logic [2:0][CB-1:0] mag0;
  logic [2:0]         neg0;
  // Stage 1: squares
  logic                v1, r1;
  logic [2:0][SQW-1:0] sq1;
  logic [2:0]          neg1;
  // Stage 2: sum and per-lane target 511^2 * m^2
  logic               v2, r2;

  // Step chain, index 0 is stage 2 output
  logic [NSTEP:0]                 sv;
  logic [NSTEP:0]                 sr;
  logic [NSTEP:0][SW-1:0]         ssum;
  logic [NSTEP:0][2:0][PW-1:0]    starget;
  logic [NSTEP:0][2:0][PW-1:0]    sqsq;
  logic [NSTEP:0][2:0][PW-1:0]    sqs;
  logic [NSTEP:0][2:0][UB-1:0]    sq;
  logic [NSTEP:0][2:0]            sneg;

  logic [2:0][CB-1:0] raw;
  logic [2:0][FB-1:0] field;

  assign raw[0] = s_tdata[CB-1:0];
  assign raw[1] = s_tdata[2*CB-1:CB];
  assign raw[2] = s_tdata[3*CB-1:2*CB];

  assign r2 = sr[0];
  assign v2 = sv[0];
  assign r1 = !v2 || r2;
  assign r0 = !v1 || r1;
  assign s_tready = !v0 || r0;

  // Stage 0: take the magnitude; the most negative value stays exact
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_tready) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      for (int i = 0; i < 3; i++) begin
        neg0[i] <= raw[i][CB-1];
        mag0[i] <= raw[i][CB-1] ? (~raw[i] + CB'(1)) : raw[i];
      end
    end
  end

  // Stage 1: one square per lane
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r0) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (r0 && v0) begin
      neg1 <= neg0;
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= SQW'(mag0[i]) * SQW'(mag0[i]);
      end
    end
  end

  // Stage 2: sum of squares, target by shift-add, clear the quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (r1) begin
      sv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && v1) begin
      ssum[0] <= SW'(sq1[0]) + SW'(sq1[1]) + SW'(sq1[2]);
      sneg[0] <= neg1;
      for (int i = 0; i < 3; i++) begin
        starget[0][i] <= (PW'(sq1[i]) << nnp_pkg::SCALE_SQ_HI)
                       - (PW'(sq1[i]) << nnp_pkg::SCALE_SQ_MID)
                       + PW'(sq1[i]);
        sqsq[0][i] <= '0;
        sqs[0][i]  <= '0;
        sq[0][i]   <= '0;
      end
    end
  end

  // Quotient bit steps, most significant bit first
  for (genvar g = 0; g < NSTEP; g++) begin : g_step
    nnp_bit_step #(
      .SW  (SW),
      .PW  (PW),
      .BIT (NSTEP - 1 - g)
    ) u_step (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (sv[g]),
      .in_ready   (sr[g]),
      .in_sum     (ssum[g]),
      .in_target  (starget[g]),
      .in_qsq     (sqsq[g]),
      .in_qs      (sqs[g]),
      .in_q       (sq[g]),
      .in_neg     (sneg[g]),
      .out_valid  (sv[g+1]),
      .out_ready  (sr[g+1]),
      .out_sum    (ssum[g+1]),
      .out_target (starget[g+1]),
      .out_qsq    (sqsq[g+1]),
      .out_qs     (sqs[g+1]),
      .out_q      (sq[g+1]),
      .out_neg    (sneg[g+1])
    );
  end

  // Apply signs; a zero vector packs as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      field[i] = sneg[NSTEP][i] ? (FB'(0) - FB'(sq[NSTEP][i])) : FB'(sq[NSTEP][i]);
    end
  end

  assign sr[NSTEP] = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sr[NSTEP]) begin
      m_tvalid <= sv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (sr[NSTEP] && sv[NSTEP]) begin
      if (ssum[NSTEP] == '0) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= nnp_pkg::TDATA_OUT'({field[2], field[1], field[0]});
        m_tuser <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/nnp_checker.sv
// ----------------------------------------------------------------------------
// nnp_checker
// Port-level checks for the 10:10:10 unit-normal packer.
// ----------------------------------------------------------------------------
module nnp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // a zero vector result carries an all-zero word
  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("zero vector with nonzero word");

  // magnitudes never reach 512, so no field is the most negative code
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:0] != 10'h200 && m_tdata[19:10] != 10'h200
              && m_tdata[29:20] != 10'h200 && m_tdata[31:30] == 2'b00)
    else $error("field out of range");

  // a draining output keeps the input open
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while output drains");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind normal_normalize_pack_10_10_10 nnp_checker u_nnp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/sv/tb_normal_normalize_pack_10_10_10.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_normal_normalize_pack_10_10_10
// Streams vectors into the unit-normal packer and checks every packed word
// and zero flag against an exact integer predictor, under random bursts,
// receiver stalls, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_normal_normalize_pack_10_10_10;

  localparam int unsigned CB       = 16;
  localparam int unsigned IN_W     = ((3*CB+7)/8)*8;
  localparam int          N_RANDOM = 1700;
  localparam int          LATENCY  = 13;
  localparam longint      LIMIT    = 400000;

  typedef struct packed {
    logic [nnp_pkg::WORD_BITS-1:0] word;
    logic                          zero;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [nnp_pkg::TDATA_OUT-1:0] m_tdata;
  logic m_tuser;

  normal_normalize_pack_10_10_10 #(.COMPONENT_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  logic [IN_W-1:0] vector_queue[$];   // vectors waiting to be offered
  normal_t         expected_normals[$];
  int     mismatches = 0;
  bit     in_accepted = 1'b0; // offered item taken at the last rising edge
  bit     pause_req = 1'b0;   // sender holds off until the pipe drains
  int     hold_cycles = 0;    // receiver long hold-off, counted down
  longint cycle = 0;

  // floor(511*|c|/sqrt(S)) with sign, as a 10-bit field
  function automatic logic [nnp_pkg::FIELD_BITS-1:0] unit_component(
      logic signed [CB-1:0] c, logic [63:0] sum_sq);
    logic [63:0]  mag;
    logic [127:0] target;
    logic [127:0] trial;
    logic [9:0]   q;
    logic [9:0]   t;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    target = 128'(mag * 511) * 128'(mag * 511);
    q = '0;
    for (int b = nnp_pkg::UNIT_BITS-1; b >= 0; b--) begin
      t = q | (10'd1 << b);
      trial = 128'(t) * 128'(t) * 128'(sum_sq);
      if (trial <= target) q = t;
    end
    if (c < 0) q = -q;
    return q;
  endfunction

  function automatic normal_t normalize_pack(logic [IN_W-1:0] raw);
    logic signed [CB-1:0] x, y, z;
    logic [63:0] s;
    normal_t r;
    x = raw[CB-1:0];
    y = raw[2*CB-1:CB];
    z = raw[3*CB-1:2*CB];
    s = 64'(longint'(x)*x) + 64'(longint'(y)*y) + 64'(longint'(z)*z);
    if (s == 0) begin
      r.word = '0;
      r.zero = 1'b1;
    end else begin
      r.word = {unit_component(z, s), unit_component(y, s), unit_component(x, s)};
      r.zero = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [IN_W-1:0] vec(int x, int y, int z);
    return IN_W'({z[CB-1:0], y[CB-1:0], x[CB-1:0]});
  endfunction

  // Random components: full range, small values, extremes
  function automatic int rand_comp();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 8) - 4;
      1:       return ($urandom_range(0, 1) != 0) ? -32768 : 32767;
      2:       return $urandom_range(0, 600) - 300;
      default: return $urandom_range(0, 65535) - 32768;
    endcase
  endfunction

  // Driver: bursts with random gaps; change inputs at the falling edge
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_accepted) begin
        void'(vector_queue.pop_front());
      end
      if (s_tvalid && !in_accepted) begin
        // hold the offered item until accepted
      end else if (pause_req || vector_queue.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= vector_queue[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      case ((cycle / 300) % 3)
        0:       m_tready <= 1'b1;
        1:       m_tready <= ($urandom_range(0, 3) != 0);
        default: m_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  // Monitor: predict on input accept, compare on output accept
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    cycle <= cycle + 1;
    in_accepted <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_normals.push_back(normalize_pack(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        got.word = m_tdata[nnp_pkg::WORD_BITS-1:0];
        got.zero = m_tuser;
        if (expected_normals.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item word=%h zero=%b", got.word, got.zero);
        end else begin
          want = expected_normals.pop_front();
          if (got !== want ||
              m_tdata[nnp_pkg::TDATA_OUT-1:nnp_pkg::WORD_BITS] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp word=%h zero=%b got tdata=%h zero=%b",
                       want.word, want.zero, m_tdata, got.zero);
          end
        end
      end
    end
    if (cycle > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    // directed: extremes, zero vector, axes, truncation-to-zero negatives
    vector_queue.push_back(vec(0, 0, 0));
    vector_queue.push_back(vec(1, 0, 0));
    vector_queue.push_back(vec(0, -1, 0));
    vector_queue.push_back(vec(0, 0, 32767));
    vector_queue.push_back(vec(-32768, 0, 0));
    vector_queue.push_back(vec(-32768, -32768, -32768));
    vector_queue.push_back(vec(32767, 32767, 32767));
    vector_queue.push_back(vec(-32768, 32767, -32768));
    vector_queue.push_back(vec(-1, 32767, 32767));
    vector_queue.push_back(vec(1, -32768, 0));
    vector_queue.push_back(vec(-1, 1, 1));
    vector_queue.push_back(vec(3, 4, 0));
    vector_queue.push_back(vec(-3, 0, -4));
    vector_queue.push_back(vec(2, 3, 6));
    vector_queue.push_back(vec(0, 0, 0));
    vector_queue.push_back(vec(-21845, 21845, -21845));
    vector_queue.push_back(vec(12345, -23456, 7));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      vector_queue.push_back(vec(rand_comp(), rand_comp(), rand_comp()));
      if (i == 500) begin
        // let the sender fill the pipe against a long receiver hold-off
        wait (vector_queue.size() < 20);
        @(negedge clk);
        hold_cycles <= 200;
      end
      if (i == 1000) begin
        // pause the sender until every expected item has come back
        wait (vector_queue.size() == 0 && !s_tvalid);
        pause_req = 1'b1;
        wait (expected_normals.size() == 0);
        pause_req = 1'b0;
      end
    end
    wait (vector_queue.size() == 0 && !s_tvalid);
    wait (expected_normals.size() == 0);
    repeat (LATENCY * 3) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: normal_normalize_pack_10_10_10.f
hw/rtl/nnp_pkg.sv
hw/rtl/nnp_bit_step.sv
hw/rtl/normal_normalize_pack_10_10_10.sv
hw/rtl/nnp_checker.sv
tb/sv/tb_normal_normalize_pack_10_10_10.sv
